@@ rtl/core/rv32m_pkg.sv @@
package rv32m_pkg;

  localparam int unsigned XLEN = 32;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_t;

  // One slot of the divider chain: an operation in flight
  typedef struct packed {
    logic            vld;
    op_t             op;
    logic [XLEN-1:0] a;       // raw dividend (for special cases)
    logic [XLEN-1:0] dvd;     // dividend magnitude, shifted out one bit a cell
    logic [XLEN-1:0] dvs;     // divisor magnitude
    logic [XLEN-1:0] rem;     // partial remainder
    logic [XLEN-1:0] quo;     // quotient bits gathered so far
    logic            neg_q;
    logic            neg_r;
    logic            dz;
    logic            ovf;
  } div_slot_t;

  localparam logic [XLEN-1:0] MSB_WORD = 32'h8000_0000;
  localparam logic [XLEN-1:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/rv32m_div_cell.sv @@
module rv32m_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  rv32m_pkg::div_slot_t slot_in,
  output rv32m_pkg::div_slot_t slot_out
);

  rv32m_pkg::div_slot_t slot_next;
  logic [rv32m_pkg::XLEN:0] trial;
  logic [rv32m_pkg::XLEN:0] diff;

  // Do one restoring step: bring in the next dividend bit, try subtract
  always_comb begin
    slot_next = slot_in;
    trial = {slot_in.rem, slot_in.dvd[rv32m_pkg::XLEN-1]};
    diff = trial - {1'b0, slot_in.dvs};
    slot_next.dvd = {slot_in.dvd[rv32m_pkg::XLEN-2:0], 1'b0};
    if (!diff[rv32m_pkg::XLEN]) begin
      slot_next.rem = diff[rv32m_pkg::XLEN-1:0];
      slot_next.quo = {slot_in.quo[rv32m_pkg::XLEN-2:0], 1'b1};
    end else begin
      slot_next.rem = trial[rv32m_pkg::XLEN-1:0];
      slot_next.quo = {slot_in.quo[rv32m_pkg::XLEN-2:0], 1'b0};
    end
  end

  // Advance the slot when the chain moves
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_out.vld <= 1'b0;
    end else if (en) begin
      slot_out.vld <= slot_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slot_out.op    <= slot_next.op;
      slot_out.a     <= slot_next.a;
      slot_out.dvd   <= slot_next.dvd;
      slot_out.dvs   <= slot_next.dvs;
      slot_out.rem   <= slot_next.rem;
      slot_out.quo   <= slot_next.quo;
      slot_out.neg_q <= slot_next.neg_q;
      slot_out.neg_r <= slot_next.neg_r;
      slot_out.dz    <= slot_next.dz;
      slot_out.ovf   <= slot_next.ovf;
    end
  end

endmodule

@@ rtl/core/rv32m_mul_path.sv @@
module rv32m_mul_path (
  input  logic                          clk,
  input  logic                          en,
  input  rv32m_pkg::op_t                op,
  input  logic [rv32m_pkg::XLEN-1:0]    a,
  input  logic [rv32m_pkg::XLEN-1:0]    b,
  output logic [rv32m_pkg::XLEN-1:0]    res
);

  // Split into four 16x16 partial products, one register stage each
  logic [31:0] p_ll, p_lh, p_hl, p_hh;
  logic [rv32m_pkg::XLEN-1:0] corr;
  rv32m_pkg::op_t op_s1;
  logic [63:0] prod;
  logic [rv32m_pkg::XLEN-1:0] corr_s2;
  rv32m_pkg::op_t op_s2;

  // Stage 1: partial products and sign correction
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll  <= a[15:0] * b[15:0];
      p_lh  <= a[15:0] * b[31:16];
      p_hl  <= a[31:16] * b[15:0];
      p_hh  <= a[31:16] * b[31:16];
      op_s1 <= op;
      corr  <= ((op == rv32m_pkg::OP_MULH || op == rv32m_pkg::OP_MULHSU)
                && a[31] ? b : '0) +
               ((op == rv32m_pkg::OP_MULH) && b[31] ? a : '0);
    end
  end

  // Stage 2: sum partial products
  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= {p_hh, p_ll} + {16'd0, p_lh, 16'd0} + {16'd0, p_hl, 16'd0};
      corr_s2 <= corr;
      op_s2   <= op_s1;
    end
  end

  // Pick the low word or the corrected high word
  always_comb begin
    if (op_s2 == rv32m_pkg::OP_MUL) begin
      res = prod[31:0];
    end else begin
      res = prod[63:32] - corr_s2;
    end
  end

endmodule

@@ rtl/core/rv32m_multiply_divide_unit.sv @@
// Pipeline: every operation passes through the same registers from request to result.
// Throughput: one request per cycle; a chain of 32 divider cells does one
// quotient bit each, the multiplier runs beside it on 16x16 partial products.
// The whole pipe stalls only when the output register holds an untaken result.
// Reset clears all valid flags; no request is in flight after reset.
module rv32m_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] result_word
);

  localparam int unsigned NCELL = rv32m_pkg::XLEN;

  rv32m_pkg::div_slot_t chain [NCELL+1];
  rv32m_pkg::div_slot_t head;
  rv32m_pkg::op_t       op_in;
  logic                 en;
  logic                 sgn;
  logic [31:0]          mul_res;
  logic [31:0]          div_res;
  rv32m_pkg::div_slot_t tail;
  logic [31:0]          q_fix, r_fix;

  // Move everything when the output register is free or being drained
  assign en    = !result_valid || result_ready;
  assign ready = en;
  assign op_in = rv32m_pkg::op_t'(req_type);
  assign sgn   = (op_in == rv32m_pkg::OP_DIV) || (op_in == rv32m_pkg::OP_REM);

  // Build the head slot: magnitudes, signs, special cases
  always_comb begin
    head.vld   = valid;
    head.op    = op_in;
    head.a     = operand_a;
    head.dvd   = (sgn && operand_a[31]) ? (32'd0 - operand_a) : operand_a;
    head.dvs   = (sgn && operand_b[31]) ? (32'd0 - operand_b) : operand_b;
    head.rem   = '0;
    head.quo   = '0;
    head.neg_q = sgn && (operand_a[31] != operand_b[31]);
    head.neg_r = sgn && operand_a[31];
    head.dz    = (operand_b == '0);
    head.ovf   = sgn && (operand_a == rv32m_pkg::MSB_WORD)
                 && (operand_b == rv32m_pkg::ALL_ONES);
  end

  // Register the head so the cells see a clean start
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0].vld <= head.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].op    <= head.op;
      chain[0].a     <= head.a;
      chain[0].dvd   <= head.dvd;
      chain[0].dvs   <= head.dvs;
      chain[0].rem   <= head.rem;
      chain[0].quo   <= head.quo;
      chain[0].neg_q <= head.neg_q;
      chain[0].neg_r <= head.neg_r;
      chain[0].dz    <= head.dz;
      chain[0].ovf   <= head.ovf;
    end
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rv32m_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .slot_in  (chain[i]),
      .slot_out (chain[i+1])
    );
  end

  // Multiplier, delayed to line up with the end of the chain
  rv32m_pkg::op_t       mop_d [NCELL-1];
  logic [31:0]          ma_d  [NCELL-1];
  logic [31:0]          mb_d  [NCELL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      mop_d[0] <= op_in;
      ma_d[0]  <= operand_a;
      mb_d[0]  <= operand_b;
      for (int k = 1; k < NCELL - 1; k++) begin
        mop_d[k] <= mop_d[k-1];
        ma_d[k]  <= ma_d[k-1];
        mb_d[k]  <= mb_d[k-1];
      end
    end
  end

  rv32m_mul_path u_mul (
    .clk (clk),
    .en  (en),
    .op  (mop_d[NCELL-2]),
    .a   (ma_d[NCELL-2]),
    .b   (mb_d[NCELL-2]),
    .res (mul_res)
  );

  // Fix signs and special cases at the end of the chain
  assign tail  = chain[NCELL];
  assign q_fix = tail.neg_q ? (32'd0 - tail.quo) : tail.quo;
  assign r_fix = tail.neg_r ? (32'd0 - tail.rem) : tail.rem;

  always_comb begin
    case (tail.op)
      rv32m_pkg::OP_DIV, rv32m_pkg::OP_DIVU: begin
        if (tail.dz) begin
          div_res = rv32m_pkg::ALL_ONES;
        end else if (tail.ovf) begin
          div_res = rv32m_pkg::MSB_WORD;
        end else begin
          div_res = q_fix;
        end
      end
      rv32m_pkg::OP_REM, rv32m_pkg::OP_REMU: begin
        if (tail.dz) begin
          div_res = tail.a;
        end else if (tail.ovf) begin
          div_res = '0;
        end else begin
          div_res = r_fix;
        end
      end
      default: begin
        div_res = mul_res;
      end
    endcase
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= tail.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_word <= div_res;
    end
  end

endmodule

@@ rtl/core/rv32m_checker.sv @@
module rv32m_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] result_word
);

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("result changed while stalled");

  // Input stalls exactly while the output stalls
  a_ready: assert property (@(posedge clk) disable iff (rst)
    ready == (!result_valid || result_ready))
    else $error("ready does not follow output stall");

  // A stalled request stays offered
  a_offer: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("request dropped while stalled");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result after reset");

endmodule

bind rv32m_multiply_divide_unit rv32m_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .valid        (valid),
  .ready        (ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_word  (result_word)
);

@@ dv/rv32m_result_checker.sv @@
`timescale 1ns / 100ps

module rv32m_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  input  logic        ready,
  input  logic [2:0]  req_type,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [31:0] result_word,
  output int          fail_count,
  output int          pending_count
);

  logic [31:0]    expected_words[$];
  rv32m_pkg::op_t expected_ops[$];

  // Compute the destination word of one RV32M request
  function automatic logic [31:0] rv32m_word(rv32m_pkg::op_t op, logic [31:0] a,
                                             logic [31:0] b);
    logic [63:0] uprod;
    logic [31:0] hi;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    logic [31:0] r;
    uprod = {32'd0, a} * {32'd0, b};
    hi = uprod[63:32];
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (op)
      rv32m_pkg::OP_MUL: return uprod[31:0];
      rv32m_pkg::OP_MULH: begin
        if (a[31]) hi = hi - b;
        if (b[31]) hi = hi - a;
        return hi;
      end
      rv32m_pkg::OP_MULHSU: return a[31] ? hi - b : hi;
      rv32m_pkg::OP_MULHU: return hi;
      rv32m_pkg::OP_DIV: begin
        if (b == 32'd0) return rv32m_pkg::ALL_ONES;
        if (a == rv32m_pkg::MSB_WORD && b == rv32m_pkg::ALL_ONES) return rv32m_pkg::MSB_WORD;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
      end
      rv32m_pkg::OP_DIVU: return (b == 32'd0) ? rv32m_pkg::ALL_ONES : a / b;
      rv32m_pkg::OP_REM: begin
        if (b == 32'd0) return a;
        if (a == rv32m_pkg::MSB_WORD && b == rv32m_pkg::ALL_ONES) return 32'd0;
        r = ma % mb;
        return a[31] ? -r : r;
      end
      default: return (b == 32'd0) ? a : a % b;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
  end

  assign pending_count = expected_words.size();

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (valid && ready) begin
        expected_words.push_back(rv32m_word(rv32m_pkg::op_t'(req_type), operand_a,
                                            operand_b));
        expected_ops.push_back(rv32m_pkg::op_t'(req_type));
      end
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", result_word));
        end else begin
          if (result_word !== expected_words[0])
            report_mismatch($sformatf("%s result_word got %h want %h",
                                      expected_ops[0].name(), result_word,
                                      expected_words[0]));
          void'(expected_words.pop_front());
          void'(expected_ops.pop_front());
        end
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 35;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] result_word;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_off_cycles;
  int          quiet_cycles;

  rv32m_multiply_divide_unit u_dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .req_type(req_type),
    .operand_a(operand_a), .operand_b(operand_b), .result_valid(result_valid),
    .result_ready(result_ready), .result_word(result_word)
  );

  rv32m_result_checker u_checker (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .req_type(req_type),
    .operand_a(operand_a), .operand_b(operand_b), .result_valid(result_valid),
    .result_ready(result_ready), .result_word(result_word),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Pick an operand biased toward corner values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return rv32m_pkg::ALL_ONES;
      2: return rv32m_pkg::MSB_WORD;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      5: return $urandom_range(0, 15);
      6: return -$urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_request(rv32m_pkg::op_t op, logic [31:0] a, logic [31:0] b);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!ready) @(posedge clk);
  endtask

  // Drive result_ready: random idling, with one long hold-off in the last random phase
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      result_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (valid && ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] corners[6];
    int          waited;
    corners = '{32'd0, 32'd1, rv32m_pkg::ALL_ONES, rv32m_pkg::MSB_WORD, 32'h7FFF_FFFF,
                32'd7};
    rst = 1'b1;
    valid = 1'b0;
    req_type = rv32m_pkg::OP_MUL;
    operand_a = 32'd0;
    operand_b = 32'd0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation on corners, division by zero, signed overflow
    for (int k = 0; k < 8; k++) begin
      send_request(rv32m_pkg::op_t'(k), corners[k % 6], corners[(k + 3) % 6]);
      send_request(rv32m_pkg::op_t'(k), rv32m_pkg::MSB_WORD, rv32m_pkg::ALL_ONES);
    end
    send_request(rv32m_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd0);
    send_request(rv32m_pkg::OP_DIVU, 32'h1234_5678, 32'd0);
    send_request(rv32m_pkg::OP_REM, 32'hFFFF_FFF9, 32'd0);
    send_request(rv32m_pkg::OP_REMU, 32'h1234_5678, 32'd0);
    send_request(rv32m_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2);
    send_request(rv32m_pkg::OP_REM, 32'hFFFF_FFF9, 32'd2);
    send_request(rv32m_pkg::OP_MULH, rv32m_pkg::ALL_ONES, rv32m_pkg::ALL_ONES);

    // Random phases with differing idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 23 : 0;
      if (phase == 2) hold_off_cycles = 300;
      for (int n = 0; n < 530; n++)
        send_request(rv32m_pkg::op_t'($urandom_range(0, 7)), pick_operand(),
                     pick_operand());
    end
    valid <= 1'b0;

    waited = 0;
    while (pending_count > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
